// ===== hdl/svfu_pkg.sv =====
// Shared constants, op codes and helper functions for the script VM variable and flow unit.
package svfu_pkg;

  localparam int VAR_COUNT_DEF   = 256;
  localparam int STACK_DEPTH_DEF = 256;

  localparam int OP_W   = 5;
  localparam int IDX8_W = 8;
  localparam int DATA_W = 16;
  localparam int PC_W   = 16;
  localparam int FLT_W  = 2;

  localparam logic [OP_W-1:0] OP_START    = 5'd0;
  localparam logic [OP_W-1:0] OP_LOADI    = 5'd1;
  localparam logic [OP_W-1:0] OP_MOV      = 5'd2;
  localparam logic [OP_W-1:0] OP_ADD      = 5'd3;
  localparam logic [OP_W-1:0] OP_ADDI     = 5'd4;
  localparam logic [OP_W-1:0] OP_SUB      = 5'd5;
  localparam logic [OP_W-1:0] OP_AND      = 5'd6;
  localparam logic [OP_W-1:0] OP_OR       = 5'd7;
  localparam logic [OP_W-1:0] OP_SHL      = 5'd8;
  localparam logic [OP_W-1:0] OP_SHR      = 5'd9;
  localparam logic [OP_W-1:0] OP_JMP      = 5'd10;
  localparam logic [OP_W-1:0] OP_JNZ      = 5'd11;
  localparam logic [OP_W-1:0] OP_CMPJMP   = 5'd12;
  localparam logic [OP_W-1:0] OP_CALL     = 5'd13;
  localparam logic [OP_W-1:0] OP_RET      = 5'd14;
  localparam logic [OP_W-1:0] OP_BRK      = 5'd15;
  localparam logic [OP_W-1:0] OP_HALT     = 5'd16;
  // internal no-op marker; an undefined code, so it behaves like one
  localparam logic [OP_W-1:0] OP_NONE     = 5'd31;

  localparam logic [FLT_W-1:0] FAULT_NONE = 2'd0;
  localparam logic [FLT_W-1:0] FAULT_OVF  = 2'd1;
  localparam logic [FLT_W-1:0] FAULT_UNF  = 2'd2;

  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_NE = 3'd1;
  localparam logic [2:0] CMP_GT = 3'd2;
  localparam logic [2:0] CMP_GE = 3'd3;
  localparam logic [2:0] CMP_LT = 3'd4;
  localparam logic [2:0] CMP_LE = 3'd5;

  localparam int COND_VAR_BIT = 7;
  localparam int COND_IMM_BIT = 6;

  localparam logic [IDX8_W-1:0] VAR_SPECIAL_IDX = 8'h54;
  localparam logic [DATA_W-1:0] VAR_SPECIAL_VAL = 16'h0081;
  localparam logic [PC_W-1:0]   PC_STOP         = 16'hFFFF;

  // idx mod count for count in 16..256: quotient < 16, so four compare/subtract steps
  function automatic logic [IDX8_W-1:0] var_wrap(input logic [IDX8_W-1:0] idx,
                                                 input int count);
    logic [11:0] r;
    logic [11:0] m;
    r = {4'd0, idx};
    for (int k = 3; k >= 0; k--) begin
      m = 12'(count << k);
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[IDX8_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] var_reset_val(input logic [IDX8_W-1:0] idx);
    return (idx == VAR_SPECIAL_IDX) ? VAR_SPECIAL_VAL : '0;
  endfunction

endpackage

// ===== hdl/svfu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module svfu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/script_vm_var_and_flow_unit.sv =====
// Top level of the script VM variable and flow unit: decode, RAM read, execute and result register.
//
// Executes one decoded instruction per request against a variable file of VAR_COUNT signed
// 16-bit entries and a return stack of STACK_DEPTH addresses, returning one result per request.
// Sustained rate is one instruction per cycle unless a held result stalls; a request is registered
// in the execute stage registers, its result in the output register. At accept: thread control
// (start, call, ret, break, halt, the halted state and the stack level) is resolved and the
// variable and stack RAMs are read. Execute: the registered RAM data, with forwarding of the
// write made at the accept edge, feeds the ALU and the branch compare; the result is written
// back and loaded into the output register. The registered read of the variable RAMs sets the
// latency. Two copies of the variable RAM, written together, give the two reads per instruction.
// Variables come out of reset with no clearing pass: a per-entry valid bit marks written entries,
// and an unwritten entry reads as zero, or 0x81 for variable 0x54. The return stack is not
// initialized. A held result stalls the execute stage and in_ready drops until out_ready takes it.
module script_vm_var_and_flow_unit
  import svfu_pkg::*;
#(
  parameter int VAR_COUNT   = VAR_COUNT_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_op,
  input  logic [IDX8_W-1:0]        in_dst_index,
  input  logic [IDX8_W-1:0]        in_src_index,
  input  logic [DATA_W-1:0]        in_imm,
  input  logic [IDX8_W-1:0]        in_cond,
  input  logic [PC_W-1:0]          in_target,
  input  logic [PC_W-1:0]          in_next_pc,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PC_W-1:0]          out_pc_out,
  output logic                     out_halted,
  output logic [FLT_W-1:0]         out_fault,
  output logic                     out_wrote,
  output logic signed [DATA_W-1:0] out_written_value
);

  localparam int IW = $clog2(VAR_COUNT);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam logic [SW-1:0] LVL_MAX = SW'(STACK_DEPTH - 1);

  // ---------------- architectural thread state ----------------
  logic          halt_r, halt_nxt;
  logic [SW-1:0] lvl_r, lvl_nxt;

  // ---------------- execute stage registers ----------------
  logic              s1_valid_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [IW-1:0]     s1_didx_r, s1_sidx_r;
  logic [IDX8_W-1:0] s1_src_r, s1_cond_r;
  logic [DATA_W-1:0] s1_imm_r;
  logic [PC_W-1:0]   s1_target_r, s1_pc_r;
  logic              s1_halt_r;
  logic [FLT_W-1:0]  s1_fault_r;
  logic              s1_dvld_r, s1_svld_r;

  // write made at the accept edge, which the RAM read missed
  logic              fwd_vld_r;
  logic [IW-1:0]     fwd_addr_r;
  logic [DATA_W-1:0] fwd_data_r;

  // ---------------- output register ----------------
  logic              out_valid_r;
  logic [PC_W-1:0]   out_pc_r;
  logic              out_halt_r;
  logic [FLT_W-1:0]  out_fault_r;
  logic              out_wr_r;
  logic [DATA_W-1:0] out_val_r;

  logic [VAR_COUNT-1:0] vld_r;

  logic accept, s1_adv, wb_fire;
  logic [IW-1:0] in_didx, in_sidx;

  // decode results
  logic [OP_W-1:0]  op0;
  logic [PC_W-1:0]  pc0;
  logic [FLT_W-1:0] fault0;
  logic             push0, pop0;

  // RAM data
  logic [DATA_W-1:0] ram_d_rdata, ram_s_rdata, stk_rdata;

  // execute
  logic [DATA_W-1:0] dv, sv, s1_val, cmp_a;
  logic              s1_wr, take;
  logic [PC_W-1:0]   s1_pc;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;
  assign wb_fire  = s1_adv && s1_wr;

  assign in_didx = IW'(var_wrap(in_dst_index, VAR_COUNT));
  assign in_sidx = IW'(var_wrap(in_src_index, VAR_COUNT));

  // ---------------- decode: thread control resolved at accept ----------------
  always_comb begin
    halt_nxt = halt_r;
    lvl_nxt  = lvl_r;
    op0      = OP_NONE;
    pc0      = in_next_pc;
    fault0   = FAULT_NONE;
    push0    = 1'b0;
    pop0     = 1'b0;
    if (in_op == OP_START) begin
      halt_nxt = 1'b0;
      lvl_nxt  = '0;
      pc0      = in_target;
    end else if (!halt_r) begin
      case (in_op)
        OP_LOADI, OP_MOV, OP_ADD, OP_ADDI, OP_SUB, OP_AND, OP_OR,
        OP_SHL, OP_SHR, OP_JNZ, OP_CMPJMP: begin
          op0 = in_op;
        end
        OP_JMP: begin
          pc0 = in_target;
        end
        OP_CALL: begin
          if (lvl_r >= LVL_MAX) begin
            halt_nxt = 1'b1;
            fault0   = FAULT_OVF;
            pc0      = PC_STOP;
          end else begin
            push0   = 1'b1;
            lvl_nxt = lvl_r + 1'b1;
            pc0     = in_target;
          end
        end
        OP_RET: begin
          if (lvl_r == '0) begin
            halt_nxt = 1'b1;
            fault0   = FAULT_UNF;
            pc0      = PC_STOP;
          end else begin
            pop0    = 1'b1;
            lvl_nxt = lvl_r - 1'b1;
            op0     = OP_RET;
          end
        end
        OP_BRK: begin
          halt_nxt = 1'b1;
        end
        OP_HALT: begin
          halt_nxt = 1'b1;
          pc0      = PC_STOP;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- memories ----------------
  svfu_ram #(.WIDTH(DATA_W), .DEPTH(VAR_COUNT)) u_var_d (
    .clk   (clk),
    .we    (wb_fire),
    .waddr (s1_didx_r),
    .wdata (s1_val),
    .re    (accept),
    .raddr (in_didx),
    .rdata (ram_d_rdata)
  );

  svfu_ram #(.WIDTH(DATA_W), .DEPTH(VAR_COUNT)) u_var_s (
    .clk   (clk),
    .we    (wb_fire),
    .waddr (s1_didx_r),
    .wdata (s1_val),
    .re    (accept),
    .raddr (in_sidx),
    .rdata (ram_s_rdata)
  );

  // push writes at the level, pop reads one below; a single request never does both
  svfu_ram #(.WIDTH(PC_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (accept && push0),
    .waddr (lvl_r),
    .wdata (in_next_pc),
    .re    (accept && pop0),
    .raddr (lvl_r - 1'b1),
    .rdata (stk_rdata)
  );

  // ---------------- execute ----------------
  // priority: forwarded write, then RAM for written entries, else reset value
  always_comb begin
    if (fwd_vld_r && fwd_addr_r == s1_didx_r) begin
      dv = fwd_data_r;
    end else if (s1_dvld_r) begin
      dv = ram_d_rdata;
    end else begin
      dv = var_reset_val(8'(s1_didx_r));
    end
    if (fwd_vld_r && fwd_addr_r == s1_sidx_r) begin
      sv = fwd_data_r;
    end else if (s1_svld_r) begin
      sv = ram_s_rdata;
    end else begin
      sv = var_reset_val(8'(s1_sidx_r));
    end
  end

  always_comb begin
    if (s1_cond_r[COND_VAR_BIT]) begin
      cmp_a = sv;
    end else if (s1_cond_r[COND_IMM_BIT]) begin
      cmp_a = {s1_src_r, s1_imm_r[7:0]};
    end else begin
      cmp_a = {8'd0, s1_src_r};
    end
    case (s1_cond_r[2:0])
      CMP_EQ:  take = ($signed(dv) == $signed(cmp_a));
      CMP_NE:  take = ($signed(dv) != $signed(cmp_a));
      CMP_GT:  take = ($signed(dv) >  $signed(cmp_a));
      CMP_GE:  take = ($signed(dv) >= $signed(cmp_a));
      CMP_LT:  take = ($signed(dv) <  $signed(cmp_a));
      CMP_LE:  take = ($signed(dv) <= $signed(cmp_a));
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    s1_val = '0;
    s1_wr  = 1'b0;
    s1_pc  = s1_pc_r;
    case (s1_op_r)
      OP_LOADI:    begin s1_val = s1_imm_r;   s1_wr = 1'b1; end
      OP_MOV:      begin s1_val = sv;         s1_wr = 1'b1; end
      OP_ADD:      begin s1_val = dv + sv;    s1_wr = 1'b1; end
      OP_ADDI:     begin s1_val = dv + s1_imm_r; s1_wr = 1'b1; end
      OP_SUB:      begin s1_val = dv - sv;    s1_wr = 1'b1; end
      OP_AND:      begin s1_val = dv & s1_imm_r; s1_wr = 1'b1; end
      OP_OR:       begin s1_val = dv | s1_imm_r; s1_wr = 1'b1; end
      OP_SHL: begin
        s1_val = (s1_imm_r[15:4] != '0) ? '0 : (dv << s1_imm_r[3:0]);
        s1_wr  = 1'b1;
      end
      OP_SHR: begin
        s1_val = (s1_imm_r[15:4] != '0) ? '0 : (dv >> s1_imm_r[3:0]);
        s1_wr  = 1'b1;
      end
      OP_JNZ: begin
        s1_val = dv - 1'b1;
        s1_wr  = 1'b1;
        if (s1_val != '0) begin
          s1_pc = s1_target_r;
        end
      end
      OP_CMPJMP: begin
        if (take) begin
          s1_pc = s1_target_r;
        end
      end
      OP_RET: begin
        s1_pc = stk_rdata;
      end
      default: begin
      end
    endcase
  end

  // ---------------- sequential ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_r      <= 1'b0;
      lvl_r       <= '0;
      s1_valid_r  <= 1'b0;
      fwd_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      if (accept) begin
        halt_r    <= halt_nxt;
        lvl_r     <= lvl_nxt;
        fwd_vld_r <= wb_fire;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (wb_fire) begin
        vld_r[s1_didx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r     <= op0;
      s1_didx_r   <= in_didx;
      s1_sidx_r   <= in_sidx;
      s1_src_r    <= in_src_index;
      s1_cond_r   <= in_cond;
      s1_imm_r    <= in_imm;
      s1_target_r <= in_target;
      s1_pc_r     <= pc0;
      s1_halt_r   <= halt_nxt;
      s1_fault_r  <= fault0;
      s1_dvld_r   <= vld_r[in_didx];
      s1_svld_r   <= vld_r[in_sidx];
      fwd_addr_r  <= s1_didx_r;
      fwd_data_r  <= s1_val;
    end
    if (s1_adv) begin
      out_pc_r    <= s1_pc;
      out_halt_r  <= s1_halt_r;
      out_fault_r <= s1_fault_r;
      out_wr_r    <= s1_wr;
      out_val_r   <= s1_val;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pc_out        = out_pc_r;
  assign out_halted        = out_halt_r;
  assign out_fault         = out_fault_r;
  assign out_wrote         = out_wr_r;
  assign out_written_value = $signed(out_val_r);

  // ---------------- assertions ----------------
  a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault != FAULT_NONE) |-> (out_halted && out_pc_out == PC_STOP))
    else $error("fault reported without halt");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_wrote) |-> (out_written_value == '0))
    else $error("written value nonzero without a write");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_START) |=> (!halt_r && lvl_r == '0))
    else $error("thread start did not clear control state");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("request taken while execute stage is stalled");

  a_fwd_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !wb_fire) |=> !fwd_vld_r)
    else $error("forwarding armed without a write-back");

endmodule

// ===== test/vm_flow_checker.sv =====
// Result checker for the script VM variable and flow unit: predicts every request and compares.
module vm_flow_checker
  import svfu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [OP_W-1:0]          in_op,
  input  logic [IDX8_W-1:0]        in_dst_index,
  input  logic [IDX8_W-1:0]        in_src_index,
  input  logic [DATA_W-1:0]        in_imm,
  input  logic [IDX8_W-1:0]        in_cond,
  input  logic [PC_W-1:0]          in_target,
  input  logic [PC_W-1:0]          in_next_pc,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [PC_W-1:0]          out_pc_out,
  input  logic                     out_halted,
  input  logic [FLT_W-1:0]         out_fault,
  input  logic                     out_wrote,
  input  logic signed [DATA_W-1:0] out_written_value,
  output int                       mismatch_count,
  output int                       pending
);

  typedef struct packed {
    logic [PC_W-1:0]   pc;
    logic              halted;
    logic [FLT_W-1:0]  fault;
    logic              wrote;
    logic [DATA_W-1:0] value;
  } vm_result_t;

  logic [DATA_W-1:0] var_file [256];
  logic [PC_W-1:0]   ret_stack [256];
  int unsigned       call_level;
  bit                stopped;
  vm_result_t        results_due [$];

  task automatic clear_state();
    for (int i = 0; i < 256; i++) begin
      var_file[i] = (i == VAR_SPECIAL_IDX) ? VAR_SPECIAL_VAL : '0;
    end
    call_level = 0;
    stopped = 1'b0;
  endtask

  // one instruction against the shadow machine
  task automatic execute(input logic [OP_W-1:0] op, input logic [IDX8_W-1:0] dst,
                         input logic [IDX8_W-1:0] src, input logic [DATA_W-1:0] imm,
                         input logic [IDX8_W-1:0] cnd, input logic [PC_W-1:0] tgt,
                         input logic [PC_W-1:0] nxt, output vm_result_t r);
    logic [DATA_W-1:0]        dv;
    logic [DATA_W-1:0]        sv;
    logic [DATA_W-1:0]        val;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic [PC_W-1:0]          pc;
    logic [FLT_W-1:0]         flt;
    bit                       wr;
    bit                       take;
    dv = var_file[dst];
    sv = var_file[src];
    pc = nxt;
    flt = FAULT_NONE;
    val = '0;
    wr = 1'b0;
    take = 1'b0;
    if (op == OP_START) begin
      call_level = 0;
      stopped = 1'b0;
      pc = tgt;
    end else if (!stopped) begin
      case (op)
        OP_LOADI:    begin val = imm; wr = 1'b1; end
        OP_MOV:      begin val = sv; wr = 1'b1; end
        OP_ADD:      begin val = dv + sv; wr = 1'b1; end
        OP_ADDI:     begin val = dv + imm; wr = 1'b1; end
        OP_SUB:      begin val = dv - sv; wr = 1'b1; end
        OP_AND:      begin val = dv & imm; wr = 1'b1; end
        OP_OR:       begin val = dv | imm; wr = 1'b1; end
        OP_SHL:      begin val = (imm >= 16) ? '0 : (dv << imm[3:0]); wr = 1'b1; end
        OP_SHR:      begin val = (imm >= 16) ? '0 : (dv >> imm[3:0]); wr = 1'b1; end
        OP_JMP:      pc = tgt;
        OP_JNZ: begin
          val = dv - 16'd1;
          wr = 1'b1;
          if (val != '0) pc = tgt;
        end
        OP_CMPJMP: begin
          b = dv;
          if (cnd[COND_VAR_BIT]) a = sv;
          else if (cnd[COND_IMM_BIT]) a = {src, imm[7:0]};
          else a = {8'h00, src};
          case (cnd[2:0])
            CMP_EQ:  take = (b == a);
            CMP_NE:  take = (b != a);
            CMP_GT:  take = (b > a);
            CMP_GE:  take = (b >= a);
            CMP_LT:  take = (b < a);
            CMP_LE:  take = (b <= a);
            default: take = 1'b0;
          endcase
          if (take) pc = tgt;
        end
        OP_CALL: begin
          if (call_level >= STACK_DEPTH_DEF - 1) begin
            stopped = 1'b1;
            flt = FAULT_OVF;
            pc = PC_STOP;
          end else begin
            ret_stack[call_level] = nxt;
            call_level++;
            pc = tgt;
          end
        end
        OP_RET: begin
          if (call_level == 0) begin
            stopped = 1'b1;
            flt = FAULT_UNF;
            pc = PC_STOP;
          end else begin
            call_level--;
            pc = ret_stack[call_level];
          end
        end
        OP_BRK: stopped = 1'b1;
        OP_HALT: begin
          stopped = 1'b1;
          pc = PC_STOP;
        end
        default: ;
      endcase
    end
    if (wr) var_file[dst] = val;
    r = '{pc: pc, halted: stopped, fault: flt, wrote: wr, value: val};
  endtask

  task automatic report(input string what, input logic [DATA_W-1:0] exp_v,
                        input logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h got %h", $time, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : watch
    vm_result_t exp_r;
    if (!rst_n) begin
      clear_state();
      results_due.delete();
      mismatch_count = 0;
    end else begin
      // drain first: a result never belongs to a request accepted at the same edge
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none got pc %h", $time, out_pc_out);
        end else begin
          exp_r = results_due.pop_front();
          report("pc_out", exp_r.pc, out_pc_out);
          report("halted", 16'(exp_r.halted), 16'(out_halted));
          report("fault", 16'(exp_r.fault), 16'(out_fault));
          report("wrote", 16'(exp_r.wrote), 16'(out_wrote));
          report("written_value", exp_r.value, out_written_value);
        end
      end
      if (in_valid && in_ready) begin
        execute(in_op, in_dst_index, in_src_index, in_imm, in_cond, in_target, in_next_pc,
                exp_r);
        results_due.push_back(exp_r);
      end
    end
    pending <= results_due.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the script VM variable and flow unit testbench: stimulus, handshakes and verdict.
module testbench;
  import svfu_pkg::*;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [OP_W-1:0]          in_op;
  logic [IDX8_W-1:0]        in_dst_index;
  logic [IDX8_W-1:0]        in_src_index;
  logic [DATA_W-1:0]        in_imm;
  logic [IDX8_W-1:0]        in_cond;
  logic [PC_W-1:0]          in_target;
  logic [PC_W-1:0]          in_next_pc;
  logic                     out_valid;
  logic                     out_ready;
  logic [PC_W-1:0]          out_pc_out;
  logic                     out_halted;
  logic [FLT_W-1:0]         out_fault;
  logic                     out_wrote;
  logic signed [DATA_W-1:0] out_written_value;

  int fail_count;
  int outstanding;

  // Rough view of the thread, used only to steer the stimulus: how deep the
  // return stack is and whether the thread has stopped. The checker owns the
  // exact prediction.
  int unsigned call_depth;
  bit          thread_stopped;
  // burst flags switch idling off on either side for a while
  bit          send_burst;
  bit          take_burst;

  script_vm_var_and_flow_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_dst_index      (in_dst_index),
    .in_src_index      (in_src_index),
    .in_imm            (in_imm),
    .in_cond           (in_cond),
    .in_target         (in_target),
    .in_next_pc        (in_next_pc),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pc_out        (out_pc_out),
    .out_halted        (out_halted),
    .out_fault         (out_fault),
    .out_wrote         (out_wrote),
    .out_written_value (out_written_value)
  );

  vm_flow_checker u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_dst_index      (in_dst_index),
    .in_src_index      (in_src_index),
    .in_imm            (in_imm),
    .in_cond           (in_cond),
    .in_target         (in_target),
    .in_next_pc        (in_next_pc),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pc_out        (out_pc_out),
    .out_halted        (out_halted),
    .out_fault         (out_fault),
    .out_wrote         (out_wrote),
    .out_written_value (out_written_value),
    .mismatch_count    (fail_count),
    .pending           (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #6000000;
    $display("** script_vm_var_and_flow_unit: FAILED **");
    $finish;
  end

  // Result side: a fresh random stall before each result is taken, none during a take burst.
  // out_valid comes from a register, so it is sampled at the falling edge.
  initial begin : result_side
    int  stall;
    bit  took;
    out_ready = 1'b0;
    forever begin
      if ($urandom_range(0, 19) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  // Sends one request and returns at the edge that accepted it. Valid stays
  // up across back-to-back requests so it never gets two updates in one step.
  task automatic issue(input logic [OP_W-1:0] op, input logic [IDX8_W-1:0] dst,
                       input logic [IDX8_W-1:0] src, input logic [DATA_W-1:0] imm_v,
                       input logic [IDX8_W-1:0] cnd, input logic [PC_W-1:0] tgt,
                       input logic [PC_W-1:0] nxt);
    int gap;
    bit acc;
    if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_op        <= op;
    in_dst_index <= dst;
    in_src_index <= src;
    in_imm       <= imm_v;
    in_cond      <= cnd;
    in_target    <= tgt;
    in_next_pc   <= nxt;
    in_valid     <= 1'b1;
    // in_ready may follow out_ready, which only moves at the rising edge
    do begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
    end while (!acc);
    // track the thread so later stimulus can keep it running
    if (op == OP_START) begin
      call_depth = 0;
      thread_stopped = 1'b0;
    end else if (!thread_stopped) begin
      case (op)
        OP_CALL: begin
          if (call_depth >= STACK_DEPTH_DEF - 1) thread_stopped = 1'b1;
          else call_depth++;
        end
        OP_RET: begin
          if (call_depth == 0) thread_stopped = 1'b1;
          else call_depth--;
        end
        OP_BRK, OP_HALT: thread_stopped = 1'b1;
        default: ;
      endcase
    end
  endtask

  function automatic logic [IDX8_W-1:0] pick_index();
    // a few hot variables so results feed later requests
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h02;
      3:       return 8'h03;
      4:       return VAR_SPECIAL_IDX;
      5:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_imm();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4, 5:    return 16'($urandom_range(0, 20));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [PC_W-1:0] pick_pc();
    return 16'($urandom_range(0, 65535));
  endfunction

  // Fresh thread, a chain of calls, then either a full unwind ending in an
  // empty-stack return or one call too many on the full stack.
  task automatic run_deep_stack(input int unsigned calls, input bit unwind);
    issue(OP_START, pick_index(), pick_index(), pick_imm(), 8'h00, pick_pc(), pick_pc());
    repeat (calls)
      issue(OP_CALL, pick_index(), pick_index(), pick_imm(), 8'h00, pick_pc(), pick_pc());
    if (unwind) begin
      repeat (calls + 1)
        issue(OP_RET, pick_index(), pick_index(), pick_imm(), 8'h00, pick_pc(), pick_pc());
    end else begin
      issue(OP_CALL, pick_index(), pick_index(), pick_imm(), 8'h00, pick_pc(), pick_pc());
    end
  endtask

  initial begin : stimulus
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] imm_v;
    logic [IDX8_W-1:0] cnd;
    int                effective;
    int                r;
    bit                deep_full_done;
    bit                deep_unwind_done;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_START;
    in_dst_index   = '0;
    in_src_index   = '0;
    in_imm         = '0;
    in_cond        = '0;
    in_target      = '0;
    in_next_pc     = '0;
    call_depth     = 0;
    thread_stopped = 1'b0;
    send_burst     = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: field extremes, every op, the reset value of 0x54,
    // wrapping arithmetic, long shifts, all three compare operand modes and
    // the never-taken codes, call/ret, empty-stack return, requests while
    // halted, break, halt and an unknown op code.
    issue(OP_LOADI,    8'h00, 8'h00, 16'hFFFF, 8'h00, 16'h0000, 16'h0001);
    issue(OP_LOADI,    8'hFF, 8'hFF, 16'h8000, 8'hFF, 16'hFFFF, 16'hFFFF);
    issue(OP_MOV,      8'h01, VAR_SPECIAL_IDX, 16'h0000, 8'h00, 16'h0000, 16'h0002);
    issue(OP_ADD,      8'h00, 8'hFF, 16'h0000, 8'h00, 16'h0000, 16'h0003);
    issue(OP_ADDI,     8'h01, 8'h00, 16'hFFFF, 8'h00, 16'h0000, 16'h0004);
    issue(OP_SUB,      8'hFF, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0005);
    issue(OP_AND,      8'h00, 8'h00, 16'h00FF, 8'h00, 16'h0000, 16'h0006);
    issue(OP_OR,       8'h02, 8'h00, 16'hA5A5, 8'h00, 16'h0000, 16'h0007);
    issue(OP_SHL,      8'h00, 8'h00, 16'd15,   8'h00, 16'h0000, 16'h0008);
    issue(OP_SHR,      8'h02, 8'h00, 16'd16,   8'h00, 16'h0000, 16'h0009);
    issue(OP_SHL,      8'h02, 8'h00, 16'hFFFF, 8'h00, 16'h0000, 16'h000A);
    issue(OP_JMP,      8'h00, 8'h00, 16'h0000, 8'h00, 16'h1234, 16'h000B);
    // decrement of zero wraps to 0xFFFF and jumps; of one reaches zero and falls through
    issue(OP_JNZ,      8'h03, 8'h00, 16'h0000, 8'h00, 16'h2000, 16'h000C);
    issue(OP_LOADI,    8'h03, 8'h00, 16'h0001, 8'h00, 16'h0000, 16'h000D);
    issue(OP_JNZ,      8'h03, 8'h00, 16'h0000, 8'h00, 16'h2100, 16'h000E);
    issue(OP_CMPJMP,   8'h03, 8'h03, 16'h0000, 8'h80, 16'h3000, 16'h000F);
    issue(OP_CMPJMP,   8'h02, 8'h80, 16'h0000, 8'h42, 16'h3100, 16'h0010);
    issue(OP_CMPJMP,   8'h03, 8'h00, 16'h0000, 8'h06, 16'h3200, 16'h0011);
    issue(OP_CMPJMP,   8'h03, 8'hFF, 16'h00FF, 8'hC7, 16'h3300, 16'h0012);
    issue(OP_CALL,     8'h00, 8'h00, 16'h0000, 8'h00, 16'h0100, 16'h0013);
    issue(OP_RET,      8'h00, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0014);
    issue(OP_RET,      8'h00, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0015);
    issue(OP_ADD,      8'h00, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0016);
    issue(OP_START,    8'h00, 8'h00, 16'h0000, 8'h00, 16'h0200, 16'h0017);
    issue(OP_BRK,      8'h00, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0300);
    issue(OP_START,    8'h00, 8'h00, 16'h0000, 8'h00, 16'h0400, 16'h0018);
    issue(OP_HALT,     8'h00, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0019);
    issue(OP_START,    8'h00, 8'h00, 16'h0000, 8'h00, 16'h0500, 16'h001A);
    issue(OP_NONE,     8'h00, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h001B);

    // Random part: mostly a running thread with random operands; halts and
    // faults are followed soon by a restart so the stack gets deep.
    effective = 0;
    deep_full_done = 1'b0;
    deep_unwind_done = 1'b0;
    while (effective < 1450) begin
      if (!deep_full_done && effective >= 300) begin
        run_deep_stack(STACK_DEPTH_DEF - 1, 1'b0);
        deep_full_done = 1'b1;
        effective += STACK_DEPTH_DEF + 1;
      end
      if (!deep_unwind_done && effective >= 900) begin
        run_deep_stack(200, 1'b1);
        deep_unwind_done = 1'b1;
        effective += 402;
      end
      r = $urandom_range(0, 99);
      if (thread_stopped && r < 60) op = OP_START;
      else if (r < 3) op = 5'($urandom_range(17, 31));
      else if (r < 6) op = OP_START;
      else if (r < 8) op = OP_BRK;
      else if (r < 10) op = OP_HALT;
      else if (r < 20) op = (call_depth == 0 && $urandom_range(0, 3) != 0) ? OP_CALL : OP_RET;
      else if (r < 30) op = OP_CALL;
      else op = 5'($urandom_range(1, 12));

      imm_v = pick_imm();
      cnd = 8'($urandom_range(0, 255));
      if (op == OP_START || !thread_stopped) effective++;
      issue(op, pick_index(), pick_index(), imm_v, cnd, pick_pc(), pick_pc());
    end
    in_valid <= 1'b0;

    // let the checker see the last request before trusting its count
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("** script_vm_var_and_flow_unit: PASSED **");
    end else begin
      $display("** script_vm_var_and_flow_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== script_vm_var_and_flow_unit.f =====
hdl/svfu_pkg.sv
hdl/svfu_ram.sv
hdl/script_vm_var_and_flow_unit.sv
test/vm_flow_checker.sv
test/testbench.sv
